// ===== design/trq_pkg.sv =====
// shared types, codes and helpers for the timed reminder queue
package trq_pkg;

    // packed due time {year, month, day, hours, minutes} and tag widths
    localparam int TIME_W = 32;
    localparam int TAG_W  = 8;

    // default number of queue cells
    localparam int DEFAULT_DEPTH = 16;

    // request function codes
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_INSERT = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_REJ_PAST = 3'd2,
        ST_REJ_FULL = 3'd3,
        ST_EXPIRED  = 3'd4
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } trq_ctl_t;

    // pack calendar fields so a plain unsigned compare orders them
    function automatic logic [TIME_W-1:0] pack_time(
        input logic [11:0] year,
        input logic [3:0]  month,
        input logic [4:0]  day,
        input logic [4:0]  hours,
        input logic [5:0]  minutes
    );
        pack_time = {year, month, day, hours, minutes};
    endfunction

endpackage

// ===== design/trq_cell.sv =====
// one queue cell: holds an entry and trades it with its neighbors
module trq_cell (
    input  logic                        clk,
    input  trq_pkg::trq_ctl_t           ctl,
    input  logic                        occupied,
    input  logic [trq_pkg::TIME_W-1:0]  new_time,
    input  logic [trq_pkg::TAG_W-1:0]   new_tag,
    input  logic                        left_ge,
    input  logic [trq_pkg::TIME_W-1:0]  left_time,
    input  logic [trq_pkg::TAG_W-1:0]   left_tag,
    input  logic [trq_pkg::TIME_W-1:0]  right_time,
    input  logic [trq_pkg::TAG_W-1:0]   right_tag,
    output logic                        ge,
    output logic [trq_pkg::TIME_W-1:0]  cell_time,
    output logic [trq_pkg::TAG_W-1:0]   cell_tag
);
    import trq_pkg::*;

    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [TAG_W-1:0]  tag_next;

    // new entry belongs here or further left: empty cell or entry not earlier
    assign ge = !occupied || (time_reg >= new_time);

    // insert shifts right from the insert point, pop shifts everything left
    always_comb
    begin
        time_next = time_reg;
        tag_next  = tag_reg;
        if (ctl.ins)
        begin
            if (left_ge)
            begin
                time_next = left_time;
                tag_next  = left_tag;
            end
            else if (ge)
            begin
                time_next = new_time;
                tag_next  = new_tag;
            end
        end
        else if (ctl.pop)
        begin
            time_next = right_time;
            tag_next  = right_tag;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        tag_reg  <= tag_next;
    end

    assign cell_time = time_reg;
    assign cell_tag  = tag_reg;

endmodule

// ===== design/timed_reminder_queue.sv =====
// top level of the timed reminder queue: request control, cell row, results
//
// A request is taken at a rising edge with start high and busy low. func selects
// a tick (compare now_* against the head, pop it when the current time is
// strictly later) or an insert (new_* with new_tag, placed in due-time order
// ahead of entries with equal time, when it lies strictly after now_* and the
// queue has room). Seconds do not exist; times compare year, month, day, hour,
// minute as plain numbers.
// Latency: the request is registered at the accepting edge, the cell row and
// count update at the end of the following cycle (busy high), and the result
// is shown on status, tag and entry_count for exactly one cycle with done high.
// A new request is not taken until the previous one has passed the request
// register and the cell row update (busy high meanwhile); every cell compares
// its entry against the request in parallel and trades entries with neighbors.
// Each request gives exactly one result; the receiver cannot stall and must
// take it in the done cycle.
// Reset clears the entry count, busy and done; cell contents are never read
// above the count and need no reset.
module timed_reminder_queue #(
    parameter int QUEUE_DEPTH = trq_pkg::DEFAULT_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic [11:0]                        now_year,
    input  logic [3:0]                         now_month,
    input  logic [4:0]                         now_day,
    input  logic [4:0]                         now_hours,
    input  logic [5:0]                         now_minutes,
    input  logic [11:0]                        new_year,
    input  logic [3:0]                         new_month,
    input  logic [4:0]                         new_day,
    input  logic [4:0]                         new_hours,
    input  logic [5:0]                         new_minutes,
    input  logic [trq_pkg::TAG_W-1:0]          new_tag,
    output logic                               done,
    output logic [2:0]                         status,
    output logic [trq_pkg::TAG_W-1:0]          tag,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   entry_count
);
    import trq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              func_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] due_reg;
    logic [TAG_W-1:0]  ntag_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    status_t           status_reg;
    status_t           status_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [TAG_W-1:0]  tag_next;
    trq_ctl_t          ctl;
    logic              accept;
    logic              due_after;
    logic              full;
    logic              head_due;

    logic              cell_ge   [QUEUE_DEPTH];
    logic [TIME_W-1:0] cell_time [QUEUE_DEPTH];
    logic [TAG_W-1:0]  cell_tag  [QUEUE_DEPTH];

    assign accept = start && !busy_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            now_reg  <= pack_time(now_year, now_month, now_day, now_hours, now_minutes);
            due_reg  <= pack_time(new_year, new_month, new_day, new_hours, new_minutes);
            ntag_reg <= new_tag;
        end
    end

    // decisions against the head and the count
    assign due_after = due_reg > now_reg;
    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_due  = (count_reg != '0) && (now_reg > cell_time[0]);

    // command and result for the request in flight
    always_comb
    begin
        ctl         = '0;
        status_next = ST_NONE;
        tag_next    = '0;
        count_next  = count_reg;
        case (func_reg)
            FUNC_INSERT:
            begin
                if (!due_after)
                begin
                    status_next = ST_REJ_PAST;
                end
                else if (full)
                begin
                    status_next = ST_REJ_FULL;
                end
                else
                begin
                    ctl.ins     = busy_reg;
                    status_next = ST_ACCEPTED;
                    count_next  = count_reg + 1'b1;
                end
            end
            default:
            begin
                if (head_due)
                begin
                    ctl.pop     = busy_reg;
                    status_next = ST_EXPIRED;
                    tag_next    = cell_tag[0];
                    count_next  = count_reg - 1'b1;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= accept;
            done_reg <= busy_reg;
            if (busy_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            status_reg <= status_next;
            tag_reg    <= tag_next;
        end
    end

    // row of cells, head at index zero
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic              left_ge;
        logic [TIME_W-1:0] left_time;
        logic [TAG_W-1:0]  left_tag;
        logic [TIME_W-1:0] right_time;
        logic [TAG_W-1:0]  right_tag;
        logic              occupied;

        assign occupied = CNT_W'(i) < count_reg;

        if (i == 0)
        begin : g_head
            assign left_ge   = 1'b0;
            assign left_time = '0;
            assign left_tag  = '0;
        end
        else
        begin : g_mid
            assign left_ge   = cell_ge[i-1];
            assign left_time = cell_time[i-1];
            assign left_tag  = cell_tag[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_time = cell_time[i];
            assign right_tag  = cell_tag[i];
        end
        else
        begin : g_body
            assign right_time = cell_time[i+1];
            assign right_tag  = cell_tag[i+1];
        end

        trq_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .occupied   (occupied),
            .new_time   (due_reg),
            .new_tag    (ntag_reg),
            .left_ge    (left_ge),
            .left_time  (left_time),
            .left_tag   (left_tag),
            .right_time (right_time),
            .right_tag  (right_tag),
            .ge         (cell_ge[i]),
            .cell_time  (cell_time[i]),
            .cell_tag   (cell_tag[i])
        );
    end

    assign busy        = busy_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign tag         = tag_reg;
    assign entry_count = count_reg;

    // count stays within the row
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // every accepted request is followed by a result strobe
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done_reg)
        else $error("missing result strobe");

    // accepted insert grows the count by one
    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && done_reg && status_reg == ST_ACCEPTED
            |-> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow count");

    // expiry shrinks the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && done_reg && status_reg == ST_EXPIRED
            |-> count_reg == $past(count_reg) - 1'b1)
        else $error("expiry did not shrink count");

    // tag carries a value only on expiry
    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != ST_EXPIRED |-> tag_reg == '0)
        else $error("tag set without expiry");

endmodule

// ===== bench/reminder_queue_check.sv =====
// checker for the timed reminder queue: watches requests and results, predicts and compares
module reminder_queue_check #(
    parameter int DEPTH = trq_pkg::DEFAULT_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             func,
    input  logic [11:0]                      now_year,
    input  logic [3:0]                       now_month,
    input  logic [4:0]                       now_day,
    input  logic [4:0]                       now_hours,
    input  logic [5:0]                       now_minutes,
    input  logic [11:0]                      new_year,
    input  logic [3:0]                       new_month,
    input  logic [4:0]                       new_day,
    input  logic [4:0]                       new_hours,
    input  logic [5:0]                       new_minutes,
    input  logic [trq_pkg::TAG_W-1:0]        new_tag,
    input  logic                             done,
    input  logic [2:0]                       status,
    input  logic [trq_pkg::TAG_W-1:0]        tag,
    input  logic [$clog2(DEPTH+1)-1:0]       entry_count,
    output int                               errors,
    output int                               outstanding
);
    import trq_pkg::*;

    localparam int CW = $clog2(DEPTH+1);

    typedef struct packed {
        status_t          st;
        logic [TAG_W-1:0] tg;
        logic [CW-1:0]    cnt;
    } outcome_t;

    // results predicted for accepted requests, oldest first
    outcome_t pending_outcomes[$];
    outcome_t head_outcome;

    // shadow copy of the sorted reminder list
    logic [TIME_W-1:0] slot_due [DEPTH];
    logic [TAG_W-1:0]  slot_tag [DEPTH];
    int                held;
    int                fail_count;

    // update the shadow list for one request and queue its predicted result
    task automatic apply_request(
        input logic              f,
        input logic [TIME_W-1:0] now_t,
        input logic [TIME_W-1:0] due_t,
        input logic [TAG_W-1:0]  tg
    );
        outcome_t o;
        int       pos;
        int       i;
        o.st = ST_NONE;
        o.tg = '0;
        if (f == FUNC_INSERT)
        begin
            // past test wins over the full test
            if (!(due_t > now_t))
                o.st = ST_REJ_PAST;
            else if (held >= DEPTH)
                o.st = ST_REJ_FULL;
            else
            begin
                // newest goes ahead of equal due times
                pos = 0;
                while (pos < held && slot_due[pos] < due_t)
                    pos++;
                for (i = held; i > pos; i--)
                begin
                    slot_due[i] = slot_due[i-1];
                    slot_tag[i] = slot_tag[i-1];
                end
                slot_due[pos] = due_t;
                slot_tag[pos] = tg;
                held++;
                o.st = ST_ACCEPTED;
            end
        end
        else if (held > 0 && now_t > slot_due[0])
        begin
            // head is overdue: pop it
            o.tg = slot_tag[0];
            for (i = 1; i < held; i++)
            begin
                slot_due[i-1] = slot_due[i];
                slot_tag[i-1] = slot_tag[i];
            end
            held--;
            o.st = ST_EXPIRED;
        end
        o.cnt = CW'(held);
        pending_outcomes.push_back(o);
    endtask

    // compare results first, then take in the request of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            fail_count = 0;
            pending_outcomes.delete();
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result with no request waiting: status %0d tag %0d entry_count %0d",
                           status, tag, entry_count);
                    fail_count++;
                end
                else
                begin
                    head_outcome = pending_outcomes.pop_front();
                    if (status !== head_outcome.st)
                    begin
                        $error("status: expected %0d, got %0d", head_outcome.st, status);
                        fail_count++;
                    end
                    if (tag !== head_outcome.tg)
                    begin
                        $error("tag: expected %0d, got %0d", head_outcome.tg, tag);
                        fail_count++;
                    end
                    if (entry_count !== head_outcome.cnt)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               head_outcome.cnt, entry_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                apply_request(func,
                              {now_year, now_month, now_day, now_hours, now_minutes},
                              {new_year, new_month, new_day, new_hours, new_minutes},
                              new_tag);
            errors <= fail_count;
            outstanding <= pending_outcomes.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
// testbench top for the timed reminder queue: clock, reset, request stimulus and verdict
module tb;
    import trq_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;
    localparam int CW    = $clog2(DEPTH+1);
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic              func        = 1'b0;
    logic [11:0]       now_year    = '0;
    logic [3:0]        now_month   = '0;
    logic [4:0]        now_day     = '0;
    logic [4:0]        now_hours   = '0;
    logic [5:0]        now_minutes = '0;
    logic [11:0]       new_year    = '0;
    logic [3:0]        new_month   = '0;
    logic [4:0]        new_day     = '0;
    logic [4:0]        new_hours   = '0;
    logic [5:0]        new_minutes = '0;
    logic [TAG_W-1:0]  new_tag     = '0;
    logic              busy;
    logic              done;
    logic [2:0]        status;
    logic [TAG_W-1:0]  tag;
    logic [CW-1:0]     entry_count;
    int                errors;
    int                outstanding;

    // running calendar for well-formed stimulus
    logic [11:0]       base_year;
    int unsigned       clock_mins;
    int unsigned       ins_pct;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    timed_reminder_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .now_year(now_year), .now_month(now_month), .now_day(now_day),
        .now_hours(now_hours), .now_minutes(now_minutes),
        .new_year(new_year), .new_month(new_month), .new_day(new_day),
        .new_hours(new_hours), .new_minutes(new_minutes), .new_tag(new_tag),
        .done(done), .status(status), .tag(tag), .entry_count(entry_count)
    );

    reminder_queue_check #(
        .DEPTH(DEPTH)
    ) i_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .now_year(now_year), .now_month(now_month), .now_day(now_day),
        .now_hours(now_hours), .now_minutes(now_minutes),
        .new_year(new_year), .new_month(new_month), .new_day(new_day),
        .new_hours(new_hours), .new_minutes(new_minutes), .new_tag(new_tag),
        .done(done), .status(status), .tag(tag), .entry_count(entry_count),
        .errors(errors), .outstanding(outstanding)
    );

    // packed calendar time from a minute counter, fields kept in range
    function automatic logic [TIME_W-1:0] wall_time(input logic [11:0] yr,
                                                    input int unsigned mins);
        logic [5:0]  mi;
        logic [4:0]  hr;
        logic [4:0]  dy;
        logic [3:0]  mo;
        logic [11:0] y;
        mi = 6'(mins % 60);
        hr = 5'((mins / 60) % 24);
        dy = 5'(1 + (mins / 1440) % 28);
        mo = 4'(1 + (mins / 40320) % 12);
        y  = yr + 12'(mins / 483840);
        return {y, mo, dy, hr, mi};
    endfunction

    // drive one request and hold it until accepted
    task automatic issue(input logic f, input logic [TIME_W-1:0] now_t,
                         input logic [TIME_W-1:0] due_t, input logic [TAG_W-1:0] tg);
        start <= 1'b1;
        func <= f;
        {now_year, now_month, now_day, now_hours, now_minutes} <= now_t;
        {new_year, new_month, new_day, new_hours, new_minutes} <= due_t;
        new_tag <= tg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        int               sent;
        int               burst;
        int               gap;
        int               k;
        int unsigned      r;
        logic             f;
        logic [TIME_W-1:0] nt;
        logic [TIME_W-1:0] dt;
        logic [TAG_W-1:0] tg;
        logic [TIME_W-1:0] t0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick, past and equal inserts
        t0 = wall_time(12'd2016, 600);
        issue(FUNC_TICK, t0, '0, 8'h00);
        issue(FUNC_INSERT, t0, t0, 8'h11);
        issue(FUNC_INSERT, t0, wall_time(12'd2016, 599), 8'h22);
        // directed: extreme due times, newest ahead of an equal time
        issue(FUNC_INSERT, '0, TIME_MAX, 8'hFF);
        issue(FUNC_INSERT, '0, 32'h1, 8'h00);
        issue(FUNC_INSERT, '0, 32'h1, 8'h5A);
        // directed: tick at exactly the head time, then one minute later
        issue(FUNC_TICK, 32'h1, TIME_MAX, 8'hFF);
        issue(FUNC_TICK, 32'h2, '0, 8'h00);
        // directed: fill with ties, then full and past-over-full
        for (k = 0; k < 14; k++)
            issue(FUNC_INSERT, t0, wall_time(12'd2016, 601 + k / 3), 8'(k + 1));
        issue(FUNC_INSERT, t0, wall_time(12'd2016, 700), 8'hAA);
        issue(FUNC_INSERT, t0, t0, 8'hBB);
        issue(FUNC_TICK, TIME_MAX, '0, 8'h00);

        // random bursts of requests with idle gaps
        base_year = 12'd2016;
        clock_mins = 0;
        sent = 0;
        while (sent < 2000)
        begin
            burst = $urandom_range(1, 24);
            ins_pct = $urandom_range(20, 90);
            if ($urandom_range(0, 11) == 0)
            begin
                base_year = 12'($urandom);
                clock_mins = $urandom_range(0, 200000);
            end
            for (k = 0; k < burst; k++)
            begin
                r = $urandom_range(0, 99);
                tg = 8'($urandom);
                if (r < 8)
                begin
                    // noise: any field value, out of range included
                    f = 1'($urandom);
                    nt = $urandom;
                    dt = $urandom;
                end
                else if (r < 10)
                begin
                    // latest possible time drains the head
                    f = FUNC_TICK;
                    nt = TIME_MAX;
                    dt = $urandom;
                end
                else if ($urandom_range(0, 99) < ins_pct)
                begin
                    f = FUNC_INSERT;
                    nt = wall_time(base_year, clock_mins);
                    case ($urandom_range(0, 9))
                        0: dt = nt;
                        1: dt = (clock_mins > 30) ?
                                wall_time(base_year, clock_mins - $urandom_range(1, 30)) : nt;
                        default: dt = wall_time(base_year, clock_mins + $urandom_range(1, 25));
                    endcase
                end
                else
                begin
                    f = FUNC_TICK;
                    clock_mins += $urandom_range(0, 6);
                    nt = wall_time(base_year, clock_mins);
                    dt = $urandom;
                end
                issue(f, nt, dt, tg);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        // drain remaining results
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
